// ===== rtl/rr_adc_pkg.sv =====
// Shared constants, types and helpers for the round-robin ADC averaging scaler.
package rr_adc_pkg;

    localparam int NUM_CHANNELS = 10;
    localparam int AVG_ROUNDS   = 64;
    localparam int SAMPLE_BITS  = 12;

    localparam int CH_BITS    = $clog2(NUM_CHANNELS);
    localparam int ROUND_BITS = (AVG_ROUNDS > 1) ? $clog2(AVG_ROUNDS) : 1;
    // A sum of AVG_ROUNDS samples stays below 2**SAMPLE_BITS * AVG_ROUNDS.
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(AVG_ROUNDS);

    localparam int GAIN_BITS     = 24;
    localparam int FRAC_BITS     = 24;
    localparam int VALUE_BITS    = 16;
    localparam int CHAN_FIELD_BITS = 4;
    localparam int PROD_BITS     = SUM_BITS + GAIN_BITS;
    localparam int SCALED_BITS   = PROD_BITS - FRAC_BITS;
    localparam int SAT_BITS      = ((SCALED_BITS > VALUE_BITS) ? SCALED_BITS : VALUE_BITS) + 1;
    localparam int MUL_CNT_BITS  = $clog2(SUM_BITS + 1);

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    localparam int NUM_GAINS    = 6;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_CELL_GAIN      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOLAR_GAIN     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_ONE_GAIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_TWO_GAIN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUCK_GAIN      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYSTEM_GAIN    = 3'd5;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET [NUM_GAINS] = '{
        24'd264875, 24'd450560, 24'd198246, 24'd195789, 24'd102400, 24'd81920
    };

    // Control for the accumulator bank.
    typedef struct packed {
        logic               add_en;
        logic               clr_en;
        logic [CH_BITS-1:0] idx;
    } acc_ctl_t;

    // Start request for the serial multiplier.
    typedef struct packed {
        logic                 start;
        logic [GAIN_BITS-1:0] gain;
        logic [SUM_BITS-1:0]  sum;
    } mul_req_t;

    // Multiplier status and saturated result.
    typedef struct packed {
        logic                  busy;
        logic [VALUE_BITS-1:0] value;
    } mul_stat_t;

    // Maps a channel to the gain register that scales it.
    function automatic logic [CFG_IDX_BITS-1:0] gain_group(input logic [CH_BITS-1:0] ch);
        int c;
        c = int'(ch);
        if (c < 4) return REG_CELL_GAIN;
        if (c < 6) return REG_SOLAR_GAIN;
        if (c == 6) return REG_MOTOR_ONE_GAIN;
        if (c == 7) return REG_MOTOR_TWO_GAIN;
        if (c == 8) return REG_BUCK_GAIN;
        return REG_SYSTEM_GAIN;
    endfunction

endpackage

// ===== rtl/rr_adc_accum.sv =====
// Per-channel accumulator bank with the round-robin channel and round counters.
module rr_adc_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rr_adc_pkg::acc_ctl_t              ctl,
    input  logic [rr_adc_pkg::SAMPLE_BITS-1:0] sample,
    output logic [rr_adc_pkg::SUM_BITS-1:0]   rd_sum,
    output logic                              burst
);

    logic [rr_adc_pkg::SUM_BITS-1:0]   sums_reg [rr_adc_pkg::NUM_CHANNELS];
    logic [rr_adc_pkg::CH_BITS-1:0]    cur_reg;
    logic [rr_adc_pkg::CH_BITS-1:0]    cur_next;
    logic [rr_adc_pkg::ROUND_BITS-1:0] round_reg;
    logic [rr_adc_pkg::ROUND_BITS-1:0] round_next;
    logic [rr_adc_pkg::CH_BITS-1:0]    sel;
    logic                              wrap;
    logic                              last_round;

    // One read port: the current channel while adding, the burst index otherwise.
    assign sel        = ctl.add_en ? cur_reg : ctl.idx;
    assign rd_sum     = sums_reg[sel];
    assign wrap       = (cur_reg == rr_adc_pkg::CH_BITS'(rr_adc_pkg::NUM_CHANNELS - 1));
    assign last_round = (round_reg == rr_adc_pkg::ROUND_BITS'(rr_adc_pkg::AVG_ROUNDS - 1));
    assign burst      = ctl.add_en && wrap && last_round;

    always_comb begin
        cur_next   = cur_reg;
        round_next = round_reg;
        if (ctl.add_en) begin
            if (wrap) begin
                cur_next   = '0;
                round_next = last_round ? '0 : round_reg + 1'b1;
            end else begin
                cur_next = cur_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            round_reg <= '0;
            for (int i = 0; i < rr_adc_pkg::NUM_CHANNELS; i++) begin
                sums_reg[i] <= '0;
            end
        end else begin
            cur_reg   <= cur_next;
            round_reg <= round_next;
            if (ctl.add_en) begin
                sums_reg[cur_reg] <= rd_sum + rr_adc_pkg::SUM_BITS'(sample);
            end else if (ctl.clr_en) begin
                sums_reg[ctl.idx] <= '0;
            end
        end
    end

endmodule

// ===== rtl/rr_adc_smul.sv =====
// Shift-and-add multiplier that takes one multiplier bit per cycle, with scaling and saturation.
module rr_adc_smul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rr_adc_pkg::mul_req_t  req,
    output rr_adc_pkg::mul_stat_t stat
);

    localparam logic [rr_adc_pkg::SAT_BITS-1:0] VALUE_MAX =
        rr_adc_pkg::SAT_BITS'((1 << rr_adc_pkg::VALUE_BITS) - 1);

    logic [rr_adc_pkg::GAIN_BITS-1:0]    hi_reg;
    logic [rr_adc_pkg::SUM_BITS-1:0]     lo_reg;
    logic [rr_adc_pkg::GAIN_BITS-1:0]    gain_reg;
    logic [rr_adc_pkg::MUL_CNT_BITS-1:0] cnt_reg;
    logic                                busy_reg;
    logic [rr_adc_pkg::GAIN_BITS:0]      partial;
    logic [rr_adc_pkg::PROD_BITS-1:0]    product;
    logic [rr_adc_pkg::SAT_BITS-1:0]     scaled;

    assign partial = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, gain_reg} : '0);
    assign product = {hi_reg, lo_reg};
    assign scaled  = rr_adc_pkg::SAT_BITS'(product[rr_adc_pkg::PROD_BITS-1:rr_adc_pkg::FRAC_BITS]);

    assign stat.busy  = busy_reg;
    assign stat.value = (scaled > VALUE_MAX) ? '1 : scaled[rr_adc_pkg::VALUE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= rr_adc_pkg::MUL_CNT_BITS'(rr_adc_pkg::SUM_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == rr_adc_pkg::MUL_CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The product's low half shifts into the multiplier register as its bits retire.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            hi_reg   <= '0;
            lo_reg   <= req.sum;
            gain_reg <= req.gain;
        end else if (busy_reg) begin
            hi_reg <= partial[rr_adc_pkg::GAIN_BITS:1];
            lo_reg <= {partial[0], lo_reg[rr_adc_pkg::SUM_BITS-1:1]};
        end
    end

endmodule

// ===== rtl/round_robin_adc_average_scaler.sv =====
// Top level: gain registers, burst sequencer and output register of the ADC averaging scaler.
//
//  channel  direction  handshake           payload
//  s_       in         s_tvalid/s_tready   s_tdata: sample
//  m_       out        m_tvalid/m_tready   m_tdata: value, m_tuser: channel, m_tlast
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data: Q0.24 gain
//
// An input transfer that does not finish a block of rounds adds its sample to its channel's sum.
// The transfer that finishes the last round starts a burst over the ten channels, each one
// taken through load, 18 serial multiply steps and the result register; the burst stalls
// while the output register is full and m_tready is low; s_tready stays low until it is done.
// Reset is synchronous, active low, clears sums, counters and m_tvalid, and returns
// the gains to their reset values.
module round_robin_adc_average_scaler (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [rr_adc_pkg::IN_TDATA_BITS-1:0]      s_tdata,   // [11:0] sample
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [rr_adc_pkg::OUT_TDATA_BITS-1:0]     m_tdata,   // [15:0] value
    output logic [rr_adc_pkg::CHAN_FIELD_BITS-1:0]    m_tuser,   // [3:0] channel
    output logic                                      m_tlast,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [rr_adc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rr_adc_pkg::GAIN_BITS-1:0]          cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]                               state_reg;
    logic [1:0]                               state_next;
    logic [rr_adc_pkg::CH_BITS-1:0]           idx_reg;
    logic [rr_adc_pkg::CH_BITS-1:0]           idx_next;
    logic [rr_adc_pkg::GAIN_BITS-1:0]         gain_reg [rr_adc_pkg::NUM_GAINS];
    logic                                     m_tvalid_reg;
    logic [rr_adc_pkg::OUT_TDATA_BITS-1:0]    m_tdata_reg;
    logic [rr_adc_pkg::CHAN_FIELD_BITS-1:0]   m_tuser_reg;
    logic                                     m_tlast_reg;

    rr_adc_pkg::acc_ctl_t                     acc_ctl;
    rr_adc_pkg::mul_req_t                     mul_req;
    rr_adc_pkg::mul_stat_t                    mul_stat;
    logic [rr_adc_pkg::SUM_BITS-1:0]          rd_sum;
    logic                                     burst;
    logic                                     s_accept;
    logic                                     out_free;
    logic                                     emit;
    logic                                     last_ch;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_MUL) && !mul_stat.busy && out_free;
    assign last_ch   = (idx_reg == rr_adc_pkg::CH_BITS'(rr_adc_pkg::NUM_CHANNELS - 1));

    assign acc_ctl.add_en = s_accept;
    assign acc_ctl.clr_en = (state_reg == ST_LOAD);
    assign acc_ctl.idx    = idx_reg;

    // The sum is read and cleared in the same cycle that the multiplier loads it.
    assign mul_req.start = (state_reg == ST_LOAD);
    assign mul_req.gain  = gain_reg[rr_adc_pkg::gain_group(idx_reg)];
    assign mul_req.sum   = rd_sum;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    rr_adc_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .sample  (s_tdata[rr_adc_pkg::SAMPLE_BITS-1:0]),
        .rd_sum  (rd_sum),
        .burst   (burst)
    );

    rr_adc_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (burst) begin
                    state_next = ST_LOAD;
                    idx_next   = '0;
                end
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (emit) begin
                    if (last_ch) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < rr_adc_pkg::NUM_GAINS; i++) begin
                gain_reg[i] <= rr_adc_pkg::GAIN_RESET[i];
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Writes to an index past the last gain register are dropped.
            if (cfg_valid && cfg_ready &&
                (cfg_index < rr_adc_pkg::CFG_IDX_BITS'(rr_adc_pkg::NUM_GAINS))) begin
                gain_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= rr_adc_pkg::OUT_TDATA_BITS'(mul_stat.value);
            m_tuser_reg <= rr_adc_pkg::CHAN_FIELD_BITS'(idx_reg);
            m_tlast_reg <= last_ch;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the round-robin ADC averaging scaler: bursts of samples, gain setups.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS    = rr_adc_pkg::NUM_CHANNELS;
    localparam int AVG_ROUNDS      = rr_adc_pkg::AVG_ROUNDS;
    localparam int SAMPLE_BITS     = rr_adc_pkg::SAMPLE_BITS;
    localparam int SUM_BITS        = rr_adc_pkg::SUM_BITS;
    localparam int GAIN_BITS       = rr_adc_pkg::GAIN_BITS;
    localparam int FRAC_BITS       = rr_adc_pkg::FRAC_BITS;
    localparam int VALUE_BITS      = rr_adc_pkg::VALUE_BITS;
    localparam int CHAN_FIELD_BITS = rr_adc_pkg::CHAN_FIELD_BITS;
    localparam int IN_TDATA_BITS   = rr_adc_pkg::IN_TDATA_BITS;
    localparam int OUT_TDATA_BITS  = rr_adc_pkg::OUT_TDATA_BITS;
    localparam int NUM_GAINS       = rr_adc_pkg::NUM_GAINS;
    localparam int CFG_IDX_BITS    = rr_adc_pkg::CFG_IDX_BITS;

    localparam int BURST_SAMPLES = AVG_ROUNDS * NUM_CHANNELS;
    localparam int BURST_CYCLES  = 240;
    localparam int RANDOM_BURSTS = 5;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 64;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

    // Indexes past the gain registers; writes to them must leave every gain alone.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [CFG_IDX_BITS-1:0] GAIN_REGS [NUM_GAINS] = '{
        rr_adc_pkg::REG_CELL_GAIN, rr_adc_pkg::REG_SOLAR_GAIN, rr_adc_pkg::REG_MOTOR_ONE_GAIN,
        rr_adc_pkg::REG_MOTOR_TWO_GAIN, rr_adc_pkg::REG_BUCK_GAIN, rr_adc_pkg::REG_SYSTEM_GAIN
    };

    typedef enum logic [1:0] {GAINS_KEEP, GAINS_ZERO, GAINS_MAX, GAINS_RANDOM} gain_preset_t;
    typedef enum logic [1:0] {FILL_ZERO, FILL_FULL, FILL_RAMP, FILL_MIXED} fill_t;

    typedef struct packed {
        gain_preset_t gains;
        fill_t        fill;
        int           typed_value;   // Negative: take every value from the predictor.
    } burst_plan_t;

    typedef struct packed {
        logic [CHAN_FIELD_BITS-1:0] chan;
        logic [VALUE_BITS-1:0]      value;
        logic                       last;
    } reading_t;

    // Reset gains first, then the saturation and zero corners, then ramps under full and random gains.
    burst_plan_t directed_plan [6] = '{
        '{GAINS_KEEP,   FILL_FULL,  -1},
        '{GAINS_MAX,    FILL_FULL,  65535},
        '{GAINS_ZERO,   FILL_FULL,  0},
        '{GAINS_MAX,    FILL_ZERO,  0},
        '{GAINS_MAX,    FILL_RAMP,  -1},
        '{GAINS_RANDOM, FILL_RAMP,  -1}
    };

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [IN_TDATA_BITS-1:0]    s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_tdata;
    logic [CHAN_FIELD_BITS-1:0]  m_tuser;
    logic                        m_tlast;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [GAIN_BITS-1:0]        cfg_data = '0;

    // Predictor state.
    logic [GAIN_BITS-1:0]        gain_reg [NUM_GAINS];
    logic [SUM_BITS-1:0]         sums [NUM_CHANNELS];
    logic [CHAN_FIELD_BITS-1:0]  ch_ptr;
    int                          rounds;
    int                          typed_value = -1;

    reading_t                    readings_due [$];
    int                          fault_count = 0;
    int                          readings_seen = 0;
    bit                          no_idle = 1'b0;

    round_robin_adc_average_scaler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task note_failure(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [CFG_IDX_BITS-1:0] scale_reg_for(input int ch);
        case (ch)
            0, 1, 2, 3: return rr_adc_pkg::REG_CELL_GAIN;
            4, 5:       return rr_adc_pkg::REG_SOLAR_GAIN;
            6:          return rr_adc_pkg::REG_MOTOR_ONE_GAIN;
            7:          return rr_adc_pkg::REG_MOTOR_TWO_GAIN;
            8:          return rr_adc_pkg::REG_BUCK_GAIN;
            default:    return rr_adc_pkg::REG_SYSTEM_GAIN;
        endcase
    endfunction

    // Adds one sample to the current channel; the sample that closes the last round
    // queues a full burst of scaled readings and clears the sums.
    task fold_sample(input logic [SAMPLE_BITS-1:0] smp);
        logic [63:0] prod;
        reading_t    r;
        sums[ch_ptr] += SUM_BITS'(smp);
        if (ch_ptr == NUM_CHANNELS - 1) begin
            ch_ptr = '0;
            rounds++;
        end else begin
            ch_ptr++;
        end
        if (rounds == AVG_ROUNDS) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                prod = 64'(sums[c]) * 64'(gain_reg[scale_reg_for(c)]);
                prod = prod >> FRAC_BITS;
                r.chan  = CHAN_FIELD_BITS'(c);
                r.value = (prod > 64'hFFFF) ? '1 : prod[VALUE_BITS-1:0];
                if (typed_value >= 0) begin
                    r.value = VALUE_BITS'(typed_value);
                end
                r.last  = (c == NUM_CHANNELS - 1);
                readings_due.push_back(r);
                sums[c] = '0;
            end
            rounds = 0;
        end
    endtask

    task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_GAINS) begin
            gain_reg[idx] = val;
        end
    endtask

    task load_gains(input gain_preset_t preset);
        logic [GAIN_BITS-1:0] val;
        for (int g = 0; g < NUM_GAINS; g++) begin
            case (preset)
                GAINS_ZERO: val = '0;
                GAINS_MAX:  val = GAIN_MAX;
                default: begin
                    case ($urandom_range(3))
                        0:       val = GAIN_BITS'($urandom_range(4095));
                        1:       val = GAIN_MAX;
                        default: val = GAIN_BITS'($urandom());
                    endcase
                end
            endcase
            write_reg(GAIN_REGS[g], val);
        end
        write_reg(REG_SPARE_LO, GAIN_BITS'($urandom()));
        write_reg(REG_SPARE_HI, GAIN_BITS'($urandom()));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task offer_sample(input logic [SAMPLE_BITS-1:0] smp);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'(smp);
        do @(posedge aclk); while (!s_tready);
        fold_sample(smp);
    endtask

    // Feeds one block of rounds. With drain set, the input then holds until the whole
    // burst is back; otherwise the next block must be offered right away.
    task run_burst(input fill_t fill, input bit drain);
        logic [SAMPLE_BITS-1:0] smp;
        for (int k = 0; k < BURST_SAMPLES; k++) begin
            case (fill)
                FILL_ZERO: smp = '0;
                FILL_FULL: smp = '1;
                FILL_RAMP: smp = SAMPLE_BITS'(k * 7 + k / NUM_CHANNELS * 311);
                default: begin
                    case ($urandom_range(9))
                        0:       smp = '0;
                        1:       smp = '1;
                        default: smp = SAMPLE_BITS'($urandom_range(4095));
                    endcase
                end
            endcase
            offer_sample(smp);
        end
        if (drain) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (readings_due.size() != 0) @(posedge aclk);
            repeat (BURST_CYCLES) @(posedge aclk);
        end
    endtask

    // Result side: random stalls, and one long hold-off while the input keeps offering.
    always @(negedge aclk) begin : result_ready
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && readings_seen == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin : result_check
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
                note_failure($sformatf("unexpected reading: channel %0d value %0d last %0b",
                                       m_tuser, m_tdata, m_tlast));
            end else begin
                want = readings_due.pop_front();
                if (m_tuser !== want.chan) begin
                    note_failure($sformatf("channel: expected %0d, got %0d", want.chan, m_tuser));
                end
                if (m_tdata[VALUE_BITS-1:0] !== want.value) begin
                    note_failure($sformatf("value on channel %0d: expected %0d, got %0d",
                                           want.chan, want.value, m_tdata));
                end
                if (m_tlast !== want.last) begin
                    note_failure($sformatf("last on channel %0d: expected %0b, got %0b",
                                           want.chan, want.last, m_tlast));
                end
            end
        end
    end

    initial begin
        gain_preset_t preset;
        for (int g = 0; g < NUM_GAINS; g++) begin
            gain_reg[g] = rr_adc_pkg::GAIN_RESET[g];
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            sums[c] = '0;
        end
        ch_ptr = '0;
        rounds = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (BURST_CYCLES) @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].gains != GAINS_KEEP) begin
                load_gains(directed_plan[i].gains);
            end
            typed_value = directed_plan[i].typed_value;
            run_burst(directed_plan[i].fill, 1'b1);
        end

        typed_value = -1;
        for (int b = 0; b < RANDOM_BURSTS; b++) begin
            // One burst runs with both sides streaming at full rate.
            no_idle = (b == 3);
            case ($urandom_range(5))
                0:       preset = GAINS_MAX;
                1:       preset = GAINS_KEEP;
                default: preset = GAINS_RANDOM;
            endcase
            // The first random burst is still in flight when the second one starts,
            // so the gains must stay as they are.
            if (b == 1) begin
                preset = GAINS_KEEP;
            end
            if (preset != GAINS_KEEP) begin
                load_gains(preset);
            end
            run_burst(FILL_MIXED, b != 0);
        end

        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
